>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

>>> src/cod_pkg.sv
// ----------------------------------------------------------------------------
// cod_pkg
// Types, codes and constants of the cell occupancy debouncer.
// ----------------------------------------------------------------------------
package cod_pkg;

    localparam int CELL_COUNT_DEF = 32;
    localparam int CELL_IDX_EXT_W = 8;   // covers addresses of up to 256 cells
    localparam int CELL_COUNT_W   = 9;   // holds the cell count itself

    localparam int CMD_W      = 2;
    localparam int CELL_REQ_W = 5;
    localparam int EDGE_W     = 16;
    localparam int PROB_W     = 9;
    localparam int CNT_W      = 16;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ANALYZE    = 2'd0,
        CMD_MARK_OCC   = 2'd1,
        CMD_RECAL_CELL = 2'd2,
        CMD_RECAL_ALL  = 2'd3
    } cmd_e;

    localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_CLASSIFIER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ABS_THRESHOLD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REL_DELTA      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HYS_FRAC       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASELINE_RATE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_FRAMES  = 3'd6;

    localparam logic [7:0]       HYS_MAX   = 8'd230;
    localparam logic [8:0]       RATE_MAX  = 9'd256;
    localparam logic [15:0]      DELTA_DEF = 16'd128;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic        relative_mode;
        logic        use_classifier;
        logic [15:0] absolute_threshold;
        logic [15:0] relative_delta;
        logic [7:0]  hysteresis_frac;
        logic [8:0]  baseline_rate;
        logic [7:0]  stable_frames;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        relative_mode:      1'b0,
        use_classifier:     1'b0,
        absolute_threshold: 16'd1280,
        relative_delta:     16'd128,
        hysteresis_frac:    8'd38,
        baseline_rate:      9'd3,
        stable_frames:      8'd3
    };

    typedef struct packed {
        cmd_e                  command;
        logic [CELL_REQ_W-1:0] cell_req;
        logic [EDGE_W-1:0]     edge_mean;
        logic                  cell_enabled;
        logic [PROB_W-1:0]     class_prob;
        logic                  prob_valid;
    } item_t;

    // one cell's entry in the state memory
    typedef struct packed {
        logic              committed;
        logic              prev_raw;
        logic [CNT_W-1:0]  count;
        logic [EDGE_W-1:0] baseline;
        logic              seeded;
        logic [EDGE_W-1:0] recent_edge;
    } entry_t;

    typedef struct packed {
        logic              raw_occupied;
        logic              occupied;
        logic [EDGE_W-1:0] baseline_out;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } mem_ctl_t;

endpackage

>>> src/cod_cell_mem.sv
// ----------------------------------------------------------------------------
// cod_cell_mem
// Per-cell state memory with a registered read, with per-entry valid
// bits so that unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module cod_cell_mem #(
    parameter int DEPTH  = cod_pkg::CELL_COUNT_DEF,
    parameter int ADDR_W = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cod_pkg::mem_ctl_t  ctl,
    input  logic [ADDR_W-1:0]  rd_addr,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  cod_pkg::entry_t    wr_data,
    output cod_pkg::entry_t    rd_data
);
    import cod_pkg::*;

    entry_t           cell_mem [DEPTH];
    entry_t           rd_data_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.clr_all) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/cod_decide.sv
// ----------------------------------------------------------------------------
// cod_decide
// Hysteresis decision, debounce and baseline update for one cell entry.
// ----------------------------------------------------------------------------
module cod_decide (
    input  cod_pkg::cfg_t    cfg,
    input  cod_pkg::item_t   item,
    input  logic             in_range,
    input  cod_pkg::entry_t  cur,
    output logic             wr_en,
    output cod_pkg::entry_t  nxt,
    output cod_pkg::result_t res
);
    import cod_pkg::*;

    logic [7:0]         h;
    logic [8:0]         fac_lo;
    logic [8:0]         fac_hi;
    logic [8:0]         factor;
    logic [8:0]         rate_eff;
    logic [15:0]        delta_eff;
    logic [15:0]        thr;
    logic [15:0]        b_eff;
    logic               seed_now;
    logic               seeded_eff;
    logic [24:0]        rhs;
    logic signed [16:0] diff;
    logic signed [16:0] metric;
    logic [23:0]        lhs;
    logic               edge_raw;
    logic               cls_raw;
    logic               raw;
    logic [9:0]         p2;
    logic [7:0]         need;
    logic [CNT_W-1:0]   cnt_step;
    logic [CNT_W-1:0]   cnt_new;
    logic               comm_new;
    logic signed [26:0] a_ext;
    logic signed [26:0] d_ext;
    logic signed [26:0] ema_prod;
    logic signed [26:0] ema_v;
    logic signed [18:0] ema_step;
    logic signed [18:0] ema_sum;
    logic [15:0]        ema_b;
    logic signed [25:0] mark_x;
    logic signed [25:0] mark_r;
    logic [15:0]        mark_b;

    always_comb begin
        h         = (cfg.hysteresis_frac > HYS_MAX) ? HYS_MAX : cfg.hysteresis_frac;
        fac_lo    = 9'd256 - 9'(h);
        fac_hi    = 9'd256 + 9'(h);
        delta_eff = (cfg.relative_delta == '0) ? DELTA_DEF : cfg.relative_delta;
        thr       = cfg.relative_mode ? delta_eff : cfg.absolute_threshold;
        // exit band only for a committed cell under analyze; mark uses the enter band
        factor    = (item.command == CMD_ANALYZE && cur.committed) ? fac_lo : fac_hi;
        rhs       = 25'(thr) * 25'(factor);

        seed_now   = cfg.relative_mode && item.cell_enabled && !cur.seeded;
        seeded_eff = cur.seeded || seed_now;
        b_eff      = seed_now ? item.edge_mean : cur.baseline;
        diff       = $signed({1'b0, item.edge_mean}) - $signed({1'b0, b_eff});
        metric     = cfg.relative_mode ? diff : $signed({1'b0, item.edge_mean});
        lhs        = {metric[15:0], 8'h00};
        edge_raw   = !metric[16] &&
                     (cur.committed ? (25'(lhs) >= rhs) : (25'(lhs) > rhs));

        p2      = {item.class_prob, 1'b0};
        cls_raw = cur.committed ? (p2 >= 10'(fac_lo)) : (p2 > 10'(fac_hi));
        raw     = (cfg.use_classifier && item.prob_valid) ? cls_raw : edge_raw;

        // debounce against the committed state
        need     = (cfg.stable_frames == '0) ? 8'd1 : cfg.stable_frames;
        comm_new = cur.committed;
        cnt_new  = cur.count;
        cnt_step = '0;
        if (raw == cur.committed) begin
            cnt_new = '0;
        end else begin
            if (cur.prev_raw == raw) begin
                cnt_step = (cur.count == CNT_MAX) ? cur.count : cur.count + 16'd1;
            end else begin
                cnt_step = 16'd1;
            end
            if (cnt_step >= 16'(need)) begin
                comm_new = raw;
                cnt_new  = '0;
            end else begin
                cnt_new = cnt_step;
            end
        end

        // EMA step, round half up via floor((a*d + 128) / 256)
        rate_eff = (cfg.baseline_rate > RATE_MAX) ? RATE_MAX : cfg.baseline_rate;
        a_ext    = 27'($signed({1'b0, rate_eff}));
        d_ext    = 27'(diff);
        ema_prod = a_ext * d_ext;
        ema_v    = ema_prod + 27'sd128;
        ema_step = $signed(ema_v[26:8]);
        ema_sum  = $signed({3'b000, b_eff}) + ema_step;
        if (ema_sum[18]) begin
            ema_b = '0;
        end else if (ema_sum[17:16] != 2'b00) begin
            ema_b = 16'hFFFF;
        end else begin
            ema_b = ema_sum[15:0];
        end

        // baseline placed one enter level below the last edge
        mark_x = $signed({2'b00, cur.recent_edge, 8'h00}) - $signed({1'b0, rhs});
        mark_r = mark_x + 26'sd128;
        mark_b = (mark_x > 26'sd0) ? mark_r[23:8] : '0;

        wr_en = 1'b0;
        nxt   = cur;
        res   = '0;
        if (in_range) begin
            unique case (item.command)
                CMD_ANALYZE: begin
                    wr_en           = 1'b1;
                    nxt.recent_edge = item.edge_mean;
                    if (seed_now) begin
                        nxt.baseline = item.edge_mean;
                        nxt.seeded   = 1'b1;
                    end
                    if (item.cell_enabled) begin
                        nxt.committed = comm_new;
                        nxt.prev_raw  = raw;
                        nxt.count     = cnt_new;
                        if (!comm_new && cnt_new == '0) begin
                            if (!seeded_eff) begin
                                nxt.baseline = item.edge_mean;
                                nxt.seeded   = 1'b1;
                            end else begin
                                nxt.baseline = ema_b;
                            end
                        end
                        res.raw_occupied = raw;
                        res.occupied     = comm_new;
                    end
                    res.baseline_out = nxt.baseline;
                end
                CMD_MARK_OCC: begin
                    wr_en         = 1'b1;
                    nxt.committed = 1'b1;
                    nxt.prev_raw  = 1'b1;
                    nxt.count     = '0;
                    if (cfg.relative_mode) begin
                        nxt.baseline = mark_b;
                        nxt.seeded   = 1'b1;
                    end
                    res.raw_occupied = item.cell_enabled;
                    res.occupied     = item.cell_enabled;
                    res.baseline_out = nxt.baseline;
                end
                CMD_RECAL_CELL: begin
                    wr_en         = 1'b1;
                    nxt.committed = 1'b0;
                    nxt.prev_raw  = 1'b0;
                    nxt.count     = '0;
                    nxt.baseline  = '0;
                    nxt.seeded    = 1'b0;
                end
                CMD_RECAL_ALL: begin
                    wr_en = 1'b0;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> src/cell_occupancy_debouncer.sv
// ----------------------------------------------------------------------------
// cell_occupancy_debouncer
// Per-cell occupancy decision with hysteresis, debounce and EMA baseline.
// ----------------------------------------------------------------------------
// The accept edge reads the cell's entry from the state memory; the load
// edge in ST_CALC applies the decision, writes back any updated entry and
// loads the result register. One transaction is in flight at a time: none
// is accepted until the last is loaded, and a stalled result register holds
// ST_CALC until it drains. Valid bits clear the cell state at reset and on
// recalibrate-all, so there is no clearing pass. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while
// no transaction is open, and the block itself does not enforce this.
module cell_occupancy_debouncer #(
    parameter int CELL_COUNT = cod_pkg::CELL_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata, low bit up: command[1:0], cell_req[6:2], edge_mean[22:7],
    // cell_enabled[23], class_prob[32:24], prob_valid[33], zero fill
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cod_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata, low bit up: raw_occupied[0], occupied[1], baseline_out[17:2],
    // zero fill
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cod_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [cod_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cod_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import cod_pkg::*;

    `include "assert_macros.svh"

    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_e;

    state_e                    state_reg;
    state_e                    state_next;
    cfg_t                      cfg_reg;
    item_t                     item_reg;
    logic                      in_range_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      m_valid_reg;
    result_t                   res_reg;

    item_t                     s_item;
    logic [CELL_IDX_EXT_W-1:0] cell_ext;
    logic [ADDR_W-1:0]         s_addr;
    logic                      s_in_range;
    logic                      accept;
    logic                      load;
    mem_ctl_t                  mem_ctl;
    entry_t                    rd_entry;
    entry_t                    wr_entry;
    logic                      dec_wr_en;
    result_t                   dec_res;

    assign s_item.command      = cmd_e'(s_tdata[1:0]);
    assign s_item.cell_req     = s_tdata[6:2];
    assign s_item.edge_mean    = s_tdata[22:7];
    assign s_item.cell_enabled = s_tdata[23];
    assign s_item.class_prob   = s_tdata[32:24];
    assign s_item.prob_valid   = s_tdata[33];

    assign cell_ext   = CELL_IDX_EXT_W'(s_item.cell_req);
    assign s_addr     = cell_ext[ADDR_W-1:0];
    assign s_in_range = CELL_COUNT_W'(s_item.cell_req) < CELL_COUNT_W'(CELL_COUNT);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_CALC) && (!m_valid_reg || m_tready);

    assign mem_ctl.rd_en   = accept;
    assign mem_ctl.wr_en   = load && dec_wr_en;
    assign mem_ctl.clr_all = load && (item_reg.command == CMD_RECAL_ALL);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RELATIVE_MODE:  cfg_reg.relative_mode      <= cfg_wdata[0];
                REG_USE_CLASSIFIER: cfg_reg.use_classifier     <= cfg_wdata[0];
                REG_ABS_THRESHOLD:  cfg_reg.absolute_threshold <= cfg_wdata;
                REG_REL_DELTA:      cfg_reg.relative_delta     <= cfg_wdata;
                REG_HYS_FRAC:       cfg_reg.hysteresis_frac    <= cfg_wdata[7:0];
                REG_BASELINE_RATE:  cfg_reg.baseline_rate      <= cfg_wdata[8:0];
                REG_STABLE_FRAMES:  cfg_reg.stable_frames      <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg     <= s_item;
            in_range_reg <= s_in_range;
            addr_reg     <= s_addr;
        end
        if (load) begin
            res_reg <= dec_res;
        end
    end

    cod_cell_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .rd_addr (s_addr),
        .wr_addr (addr_reg),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    cod_decide u_decide (
        .cfg      (cfg_reg),
        .item     (item_reg),
        .in_range (in_range_reg),
        .cur      (rd_entry),
        .wr_en    (dec_wr_en),
        .nxt      (wr_entry),
        .res      (dec_res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({res_reg.baseline_out, res_reg.occupied,
                                  res_reg.raw_occupied});

    // a read and a write-back never share a cycle, so no forwarding is needed
    `ASSERT_NEVER(a_no_rd_wr_overlap, aclk, aresetn, mem_ctl.rd_en && mem_ctl.wr_en, "memory read and write in the same cycle")
    // with the result register free, ST_CALC finishes the entry without stalling
    `ASSERT_CLK(a_calc_drains, aclk, aresetn, (state_reg == ST_CALC) && !m_valid_reg |=> (state_reg == ST_IDLE) && m_valid_reg, "result not loaded after compute")
    // only one transaction is in flight
    `ASSERT_CLK(a_single_flight, aclk, aresetn, accept |=> !s_tready, "new transaction taken while one is in flight")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cell_occupancy_debouncer. A queue of frame commands
// feeds a stream driver; each accepted transaction runs through a local model
// of the per-cell hysteresis, debounce and baseline tracking. The monitor
// compares every result transaction with the oldest predicted decision.
// ----------------------------------------------------------------------------
module testbench;
    import cod_pkg::*;

    localparam int NUM_CELLS    = 32;
    localparam int NUM_SEGMENTS = 12;
    localparam int SEGMENT_LEN  = 136;
    localparam int QUIET_LIMIT  = 5000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // command, cell_req, edge_mean, cell_enabled, class_prob, prob_valid, zero fill
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // raw_occupied, occupied, baseline_out, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    cell_occupancy_debouncer #(.CELL_COUNT(NUM_CELLS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow of the register file
    logic        cfg_rel     = CFG_RESET.relative_mode;
    logic        cfg_cls     = CFG_RESET.use_classifier;
    logic [15:0] cfg_abs_thr = CFG_RESET.absolute_threshold;
    logic [15:0] cfg_delta   = CFG_RESET.relative_delta;
    logic [7:0]  cfg_hys     = CFG_RESET.hysteresis_frac;
    logic [8:0]  cfg_rate    = CFG_RESET.baseline_rate;
    logic [7:0]  cfg_stable  = CFG_RESET.stable_frames;

    // per-cell model state
    logic        cell_committed [NUM_CELLS];
    logic        cell_prev_raw  [NUM_CELLS];
    logic [15:0] cell_count     [NUM_CELLS];
    logic [15:0] cell_baseline  [NUM_CELLS];
    logic        cell_seeded    [NUM_CELLS];
    logic [15:0] cell_last_edge [NUM_CELLS];

    item_t       frame_cmds[$];
    result_t     expected_decisions[$];
    item_t       in_flight;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned scene_base [NUM_CELLS];

    function automatic void clear_cells();
        for (int c = 0; c < NUM_CELLS; c++) begin
            cell_committed[c] = 1'b0;
            cell_prev_raw[c]  = 1'b0;
            cell_count[c]     = '0;
            cell_baseline[c]  = '0;
            cell_seeded[c]    = 1'b0;
            cell_last_edge[c] = '0;
        end
    endfunction

    function automatic result_t predict_decision(input item_t it);
        result_t     r;
        int unsigned c;
        int unsigned need;
        longint      e, p, h, delta, thr, metric, b, rate, v, nb, x;
        logic        raw, comm;
        r = '0;
        c = it.cell_req;
        e = it.edge_mean;
        p = it.class_prob;
        h = cfg_hys;
        if (h > HYS_MAX) h = HYS_MAX;
        delta = (cfg_delta == 0) ? DELTA_DEF : cfg_delta;
        if (it.command == CMD_RECAL_ALL) clear_cells();

        if (it.command == CMD_ANALYZE) begin
            need = (cfg_stable == 0) ? 1 : cfg_stable;
            cell_last_edge[c] = it.edge_mean;
            if (cfg_rel && it.cell_enabled && !cell_seeded[c]) begin
                cell_baseline[c] = it.edge_mean;
                cell_seeded[c] = 1'b1;
            end
            if (!it.cell_enabled) begin
                r.baseline_out = cell_baseline[c];
                return r;
            end
            comm = cell_committed[c];
            b = cell_baseline[c];
            if (cfg_cls && it.prob_valid) begin
                raw = comm ? (2 * p >= 256 - h) : (2 * p > 256 + h);
            end else begin
                thr = cfg_rel ? delta : longint'(cfg_abs_thr);
                metric = cfg_rel ? e - b : e;
                raw = comm ? (metric * 256 >= thr * (256 - h))
                           : (metric * 256 > thr * (256 + h));
            end
            // debounce: count raw values that disagree with the committed state
            if (raw == comm) begin
                cell_count[c] = '0;
            end else begin
                if (cell_prev_raw[c] == raw) begin
                    if (cell_count[c] != CNT_MAX) cell_count[c] = cell_count[c] + 16'd1;
                end else begin
                    cell_count[c] = 16'd1;
                end
                if (cell_count[c] >= need) begin
                    cell_committed[c] = raw;
                    cell_count[c] = '0;
                end
            end
            cell_prev_raw[c] = raw;
            // baseline only tracks while empty and settled
            if (!cell_committed[c] && cell_count[c] == 0) begin
                if (!cell_seeded[c]) begin
                    cell_baseline[c] = it.edge_mean;
                    cell_seeded[c] = 1'b1;
                end else begin
                    rate = cfg_rate;
                    if (rate > RATE_MAX) rate = RATE_MAX;
                    v = rate * (e - b) + 128;
                    nb = b + (v >>> 8);
                    if (nb < 0) nb = 0;
                    if (nb > 65535) nb = 65535;
                    cell_baseline[c] = nb[15:0];
                end
            end
            r.raw_occupied = raw;
            r.occupied     = cell_committed[c];
            r.baseline_out = cell_baseline[c];
            return r;
        end

        if (it.command == CMD_MARK_OCC) begin
            cell_committed[c] = 1'b1;
            cell_prev_raw[c]  = 1'b1;
            cell_count[c]     = '0;
            if (cfg_rel) begin
                x = longint'(cell_last_edge[c]) * 256 - delta * (256 + h);
                nb = (x > 0) ? ((x + 128) >>> 8) : 0;
                if (nb > 65535) nb = 65535;
                cell_baseline[c] = nb[15:0];
                cell_seeded[c] = 1'b1;
            end
        end else if (it.command == CMD_RECAL_CELL) begin
            cell_committed[c] = 1'b0;
            cell_prev_raw[c]  = 1'b0;
            cell_count[c]     = '0;
            cell_baseline[c]  = '0;
            cell_seeded[c]    = 1'b0;
        end
        r.raw_occupied = it.cell_enabled ? cell_prev_raw[c] : 1'b0;
        r.occupied     = it.cell_enabled ? cell_committed[c] : 1'b0;
        r.baseline_out = cell_baseline[c];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // stream driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_decisions.push_back(predict_decision(in_flight));
            if (!s_tvalid || s_tready) begin
                if (frame_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_flight = frame_cmds.pop_front();
                    s_tdata  <= {6'd0, in_flight.prob_valid, in_flight.class_prob,
                                 in_flight.cell_enabled, in_flight.edge_mean,
                                 in_flight.cell_req, in_flight.command};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge aclk) begin : result_monitor
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            if (m_tvalid && m_tready) begin
                got.raw_occupied = m_tdata[0];
                got.occupied     = m_tdata[1];
                got.baseline_out = m_tdata[17:2];
                if (expected_decisions.size() == 0) begin
                    report_mismatch("unexpected result, baseline_out", got.baseline_out, 0);
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.raw_occupied !== want.raw_occupied)
                        report_mismatch("raw_occupied", got.raw_occupied, want.raw_occupied);
                    if (got.occupied !== want.occupied)
                        report_mismatch("occupied", got.occupied, want.occupied);
                    if (got.baseline_out !== want.baseline_out)
                        report_mismatch("baseline_out", got.baseline_out, want.baseline_out);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("cell_occupancy_debouncer verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_item(input cmd_e cmd, input int unsigned cell_idx,
                              input int unsigned edge_v, input logic en,
                              input int unsigned prob, input logic pv);
        item_t it;
        it = '0;
        it.command      = cmd;
        it.cell_req     = cell_idx[CELL_REQ_W-1:0];
        it.edge_mean    = edge_v[EDGE_W-1:0];
        it.cell_enabled = en;
        it.class_prob   = prob[PROB_W-1:0];
        it.prob_valid   = pv;
        frame_cmds.push_back(it);
    endtask

    task automatic wait_drained();
        while (frame_cmds.size() != 0 || expected_decisions.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RELATIVE_MODE:  cfg_rel     = val[0];
            REG_USE_CLASSIFIER: cfg_cls     = val[0];
            REG_ABS_THRESHOLD:  cfg_abs_thr = val;
            REG_REL_DELTA:      cfg_delta   = val;
            REG_HYS_FRAC:       cfg_hys     = val[7:0];
            REG_BASELINE_RATE:  cfg_rate    = val[8:0];
            REG_STABLE_FRAMES:  cfg_stable  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic rel, input logic cls, input logic [15:0] abs_thr,
                                input logic [15:0] delta, input logic [7:0] hys,
                                input logic [8:0] rate, input logic [7:0] stable);
        write_reg(REG_RELATIVE_MODE, {15'd0, rel});
        write_reg(REG_USE_CLASSIFIER, {15'd0, cls});
        write_reg(REG_ABS_THRESHOLD, abs_thr);
        write_reg(REG_REL_DELTA, delta);
        write_reg(REG_HYS_FRAC, {8'd0, hys});
        write_reg(REG_BASELINE_RATE, {7'd0, rate});
        write_reg(REG_STABLE_FRAMES, {8'd0, stable});
    endtask

    task automatic write_random_config();
        int unsigned r;
        logic [15:0] v_abs, v_delta;
        logic [7:0]  v_hys, v_stable;
        logic [8:0]  v_rate;
        r = $urandom_range(99);
        v_abs = (r < 10) ? 16'd0 : (r < 15) ? 16'hFFFF : 16'($urandom_range(100, 4000));
        r = $urandom_range(99);
        v_delta = (r < 10) ? 16'd0 : (r < 15) ? 16'd1 : 16'($urandom_range(32, 1500));
        r = $urandom_range(99);
        v_hys = (r < 15) ? 8'd0 : (r < 25) ? HYS_MAX : (r < 35) ? 8'($urandom_range(231, 255))
                                                               : 8'($urandom_range(229));
        r = $urandom_range(99);
        v_rate = (r < 15) ? 9'd0 : (r < 25) ? RATE_MAX : (r < 35) ? 9'($urandom_range(257, 511))
                                                                 : 9'($urandom_range(1, 255));
        r = $urandom_range(99);
        v_stable = (r < 10) ? 8'd0 : (r < 20) ? 8'd1 : 8'($urandom_range(2, 6));
        write_config(1'($urandom_range(1)), 1'($urandom_range(1)), v_abs, v_delta, v_hys,
                     v_rate, v_stable);
    endtask

    // Mostly runs of analyze frames that sit clearly inside or outside the
    // band so the debounce commits; the rest is other commands and noise.
    task automatic queue_random_items(input int unsigned n);
        int unsigned k, roll, cell_idx, run_len;
        logic        occ_scene;
        longint      d, base, lvl, e;
        k = 0;
        while (k < n) begin
            roll = $urandom_range(99);
            cell_idx = (roll < 60) ? $urandom_range(3) : $urandom_range(NUM_CELLS - 1);
            roll = $urandom_range(99);
            if (roll < 7) begin
                queue_item(CMD_MARK_OCC, cell_idx, $urandom_range(65535),
                           $urandom_range(9) != 0, $urandom_range(511),
                           1'($urandom_range(1)));
                k++;
            end else if (roll < 12) begin
                queue_item(CMD_RECAL_CELL, cell_idx, $urandom_range(65535),
                           1'($urandom_range(1)), $urandom_range(511),
                           1'($urandom_range(1)));
                k++;
            end else if (roll < 14) begin
                queue_item(CMD_RECAL_ALL, cell_idx, $urandom_range(65535),
                           1'($urandom_range(1)), $urandom_range(511),
                           1'($urandom_range(1)));
                k++;
            end else if (roll < 22) begin
                queue_item(CMD_ANALYZE, cell_idx, $urandom_range(65535),
                           1'($urandom_range(1)), $urandom_range(511),
                           1'($urandom_range(1)));
                k++;
            end else begin
                d = cfg_rel ? ((cfg_delta == 0) ? 128 : cfg_delta) : cfg_abs_thr;
                base = cfg_rel ? scene_base[cell_idx] : 0;
                occ_scene = 1'($urandom_range(1));
                lvl = occ_scene ? base + 2 * d + 16 : base + d / 3;
                run_len = $urandom_range(1, 8);
                for (int j = 0; j < run_len && k < n; j++) begin
                    e = lvl + $urandom_range(32'(d / 4 + 8)) - (d / 8 + 4);
                    if (e < 0) e = 0;
                    if (e > 65535) e = 65535;
                    queue_item(CMD_ANALYZE, cell_idx, 32'(e), $urandom_range(19) != 0,
                               occ_scene ? $urandom_range(150, 256) : $urandom_range(0, 105),
                               $urandom_range(4) != 0);
                    k++;
                end
            end
        end
    endtask

    initial begin
        clear_cells();
        for (int c = 0; c < NUM_CELLS; c++) scene_base[c] = $urandom_range(300, 3000);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct   = 22;
        receiver_idle_pct = 56;

        // absolute mode at reset values: enter above 1470, stay from 1090
        write_config(CFG_RESET.relative_mode, CFG_RESET.use_classifier,
                     CFG_RESET.absolute_threshold, CFG_RESET.relative_delta,
                     CFG_RESET.hysteresis_frac, CFG_RESET.baseline_rate,
                     CFG_RESET.stable_frames);
        queue_item(CMD_ANALYZE, 0, 0, 1'b1, 0, 1'b0);
        repeat (3) queue_item(CMD_ANALYZE, 1, 65535, 1'b1, 511, 1'b1);
        queue_item(CMD_ANALYZE, 1, 1090, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 1, 1089, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 2, 1470, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 2, 1471, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 3, 65535, 1'b0, 256, 1'b1);
        queue_item(CMD_MARK_OCC, 4, 0, 1'b1, 0, 1'b0);
        queue_item(CMD_MARK_OCC, 31, 65535, 1'b0, 0, 1'b0);
        queue_item(CMD_RECAL_CELL, 1, 0, 1'b1, 0, 1'b0);
        queue_item(CMD_RECAL_ALL, 31, 0, 1'b1, 511, 1'b1);
        wait_drained();

        // classifier: enter from 148, stay from 109
        write_reg(REG_USE_CLASSIFIER, 16'd1);
        queue_item(CMD_ANALYZE, 5, 0, 1'b1, 147, 1'b1);
        queue_item(CMD_ANALYZE, 5, 0, 1'b1, 148, 1'b1);
        queue_item(CMD_ANALYZE, 5, 0, 1'b1, 511, 1'b1);
        queue_item(CMD_ANALYZE, 5, 0, 1'b1, 256, 1'b0);
        wait_drained();

        // relative mode: seeding, rise detection, marking with floor at zero
        write_reg(REG_USE_CLASSIFIER, 16'd0);
        write_reg(REG_RELATIVE_MODE, 16'd1);
        queue_item(CMD_ANALYZE, 6, 1000, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 6, 1200, 1'b1, 0, 1'b0);
        queue_item(CMD_MARK_OCC, 7, 0, 1'b1, 0, 1'b0);
        queue_item(CMD_MARK_OCC, 6, 0, 1'b1, 0, 1'b0);
        queue_item(CMD_ANALYZE, 8, 65535, 1'b0, 0, 1'b0);
        queue_item(CMD_RECAL_CELL, 6, 0, 1'b1, 0, 1'b0);
        wait_drained();

        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            if (s < NUM_SEGMENTS / 3) begin
                sender_idle_pct   = 22;
                receiver_idle_pct = 56;
            end else if (s < 2 * NUM_SEGMENTS / 3) begin
                sender_idle_pct   = 56;
                receiver_idle_pct = 22;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (s)
                0: write_config(1'b1, 1'b0, 16'd0, 16'd0, 8'd255, 9'd511, 8'd0);
                1: write_config(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, HYS_MAX, RATE_MAX, 8'd255);
                2: write_config(1'b1, 1'b1, 16'd1, 16'd1, 8'd0, 9'd0, 8'd1);
                3: write_config(CFG_RESET.relative_mode, CFG_RESET.use_classifier,
                                CFG_RESET.absolute_threshold, CFG_RESET.relative_delta,
                                CFG_RESET.hysteresis_frac, CFG_RESET.baseline_rate,
                                CFG_RESET.stable_frames);
                default: write_random_config();
            endcase
            // sender holds off mid-segment until every result is back
            queue_random_items(SEGMENT_LEN / 2);
            while (frame_cmds.size() != 0 || expected_decisions.size() != 0 || s_tvalid)
                @(posedge aclk);
            queue_random_items(SEGMENT_LEN - SEGMENT_LEN / 2);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("cell_occupancy_debouncer verification clean");
        end else begin
            $display("cell_occupancy_debouncer verification failed");
        end
        $finish;
    end

endmodule
